### hw/rtl/ffsc_pkg.sv
// Shared types, constants and command codes of the field follow steering controller.
`default_nettype none
package ffsc_pkg;

  localparam int unsigned MvW      = 13;
  localparam int unsigned BufW     = 10;
  localparam int unsigned LrBufW   = 11;
  localparam int unsigned PatW     = 4;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned CmdW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ArithW   = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [ArithW-1:0] TrimMv  = 16'd15;
  localparam logic [ArithW-1:0] WidenMv = 16'd25;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBuffer   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLrBuffer = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLevel0   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLevel1   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevel2   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLevel3   = 3'd5;

  localparam logic [BufW-1:0]   BufferRst   = 10'd50;
  localparam logic [LrBufW-1:0] LrBufferRst = 11'd200;
  localparam logic [MvW-1:0]    Level0Rst   = 13'd1100;
  localparam logic [MvW-1:0]    Level1Rst   = 13'd2500;
  localparam logic [MvW-1:0]    Level2Rst   = 13'd2900;
  localparam logic [MvW-1:0]    Level3Rst   = 13'd3750;
  localparam logic [LevelW-1:0] LevelRst    = 2'd2;
  localparam logic [LevelW-1:0] LevelMax    = 2'd3;
  localparam logic [LevelW-1:0] LevelMin    = 2'd0;

  // motor patterns
  localparam logic [PatW-1:0] PatStop      = 4'h0;
  localparam logic [PatW-1:0] PatLine0     = 4'h1;
  localparam logic [PatW-1:0] PatLine1     = 4'h2;
  localparam logic [PatW-1:0] PatLine2     = 4'h4;
  localparam logic [PatW-1:0] PatLine3     = 4'h8;
  localparam logic [PatW-1:0] PatInner     = 4'h6;
  localparam logic [PatW-1:0] PatOuter     = 4'h9;

  // remote command bytes
  localparam logic [CmdW-1:0] CmdTurnA  = 8'd251;
  localparam logic [CmdW-1:0] CmdTurnB  = 8'd253;
  localparam logic [CmdW-1:0] CmdTurnC  = 8'd249;
  localparam logic [CmdW-1:0] CmdParkA  = 8'd24;
  localparam logic [CmdW-1:0] CmdParkB  = 8'd140;
  localparam logic [CmdW-1:0] CmdParkC  = 8'd136;
  localparam logic [CmdW-1:0] CmdNearA  = 8'd55;
  localparam logic [CmdW-1:0] CmdNearB  = 8'd177;
  localparam logic [CmdW-1:0] CmdNearC  = 8'd103;
  localparam logic [CmdW-1:0] CmdNearD  = 8'd39;
  localparam logic [CmdW-1:0] CmdFarA   = 8'd198;
  localparam logic [CmdW-1:0] CmdFarB   = 8'd226;
  localparam logic [CmdW-1:0] CmdFarC   = 8'd230;
  localparam logic [CmdW-1:0] CmdFarD   = 8'd134;

  typedef enum logic [1:0] {
    ManNone = 2'd0,
    ManTurn = 2'd1,
    ManPark = 2'd2
  } man_e;

  typedef struct packed {
    logic              toggle;
    man_e              man;
    logic [LevelW-1:0] level_nxt;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/ffsc_rules.sv
// Prioritized steering rules: picks the motor pattern from one sensor pair.
`default_nettype none
module ffsc_rules (
  input  logic [ffsc_pkg::MvW-1:0]    left_mv_i,
  input  logic [ffsc_pkg::MvW-1:0]    right_mv_i,
  input  logic [ffsc_pkg::MvW-1:0]    target_mv_i,
  input  logic [ffsc_pkg::BufW-1:0]   buffer_mv_i,
  input  logic [ffsc_pkg::LrBufW-1:0] lr_buffer_mv_i,
  input  logic                        backward_i,
  input  logic [ffsc_pkg::PatW-1:0]   held_i,
  output logic [ffsc_pkg::PatW-1:0]   pattern_o
);

  localparam int unsigned AW = ffsc_pkg::ArithW;

  logic signed [AW-1:0] l, r, d, b, w;
  logic signed [AW-1:0] lpb, lmb, rpb, rmb, rml, lmr, lbt, rbt, ww;

  assign l = signed'({{(AW-ffsc_pkg::MvW){1'b0}}, left_mv_i});
  assign r = signed'({{(AW-ffsc_pkg::MvW){1'b0}}, right_mv_i});
  assign d = signed'({{(AW-ffsc_pkg::MvW){1'b0}}, target_mv_i});
  assign b = signed'({{(AW-ffsc_pkg::BufW){1'b0}}, buffer_mv_i});
  assign w = signed'({{(AW-ffsc_pkg::LrBufW){1'b0}}, lr_buffer_mv_i});

  assign lpb = l + b;
  assign lmb = l - b;
  assign rpb = r + b;
  assign rmb = r - b;
  assign rml = r - l;
  assign lmr = l - r;
  assign lbt = lpb - signed'(ffsc_pkg::TrimMv);
  assign rbt = rpb - signed'(ffsc_pkg::TrimMv);
  assign ww  = w + signed'(ffsc_pkg::WidenMv);

  // later rules override earlier ones; no match holds the last pattern
  always_comb begin
    pattern_o = held_i;
    if (!backward_i) begin
      if (lpb < d && lpb < r) pattern_o = ffsc_pkg::PatLine1;
      if (rpb < d && rpb < l) pattern_o = ffsc_pkg::PatLine2;
      if (lmb > d && l > rbt) pattern_o = ffsc_pkg::PatLine0;
      if (rmb > d && r > lbt) pattern_o = ffsc_pkg::PatLine3;
      if (rmb < d && lmb < d && (rml < w || lmr < w)) pattern_o = ffsc_pkg::PatInner;
      if (rmb > d && lmb > d && (rml < ww || lmr < ww)) pattern_o = ffsc_pkg::PatOuter;
    end else begin
      if (rmb > d && r > l) pattern_o = ffsc_pkg::PatLine0;
      if (lmb > d && l > r) pattern_o = ffsc_pkg::PatLine3;
      if (rpb < d && r < l) pattern_o = ffsc_pkg::PatLine1;
      if (lpb < d && l < r) pattern_o = ffsc_pkg::PatLine2;
      if (rpb > d && lpb > d && rml < w) pattern_o = ffsc_pkg::PatInner;
      if (rpb < d && lpb < d && rml < w) pattern_o = ffsc_pkg::PatOuter;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ffsc_cmd.sv
// Remote command decoder: turn, park and distance level steps.
`default_nettype none
module ffsc_cmd (
  input  logic [ffsc_pkg::CmdW-1:0]   command_byte_i,
  input  logic [ffsc_pkg::LevelW-1:0] level_i,
  output ffsc_pkg::cmd_t              cmd_o
);

  always_comb begin
    cmd_o.toggle    = 1'b0;
    cmd_o.man       = ffsc_pkg::ManNone;
    cmd_o.level_nxt = level_i;
    unique case (command_byte_i)
      ffsc_pkg::CmdTurnA, ffsc_pkg::CmdTurnB, ffsc_pkg::CmdTurnC: begin
        cmd_o.toggle = 1'b1;
        cmd_o.man    = ffsc_pkg::ManTurn;
      end
      ffsc_pkg::CmdParkA, ffsc_pkg::CmdParkB, ffsc_pkg::CmdParkC: begin
        cmd_o.man = ffsc_pkg::ManPark;
      end
      ffsc_pkg::CmdNearA, ffsc_pkg::CmdNearB, ffsc_pkg::CmdNearC,
      ffsc_pkg::CmdNearD: begin
        if (level_i != ffsc_pkg::LevelMax) cmd_o.level_nxt = level_i + 2'd1;
      end
      ffsc_pkg::CmdFarA, ffsc_pkg::CmdFarB, ffsc_pkg::CmdFarC,
      ffsc_pkg::CmdFarD: begin
        if (level_i != ffsc_pkg::LevelMin) cmd_o.level_nxt = level_i - 2'd1;
      end
      default: begin
        cmd_o.toggle = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/field_follow_steering_controller_core.sv
// Top level of the field follow steering controller: registers, handshakes, state.
//
// Input stream (s_axis): tuser carries the opcode (0 sensor pair, 1 command
// byte); tdata carries left_mv, right_mv and command_byte. Each transfer gives
// exactly one result on the output stream (m_axis) with the motor pattern,
// manoeuvre request, orientation and distance level after that item.
// An input transfer loads the input register, and the rule and command logic
// feed the result register, which drives the output stream.
// Throughput is one item per cycle while m_axis_tready stays high; the rule
// compares and the level mux between those two registers set the clock period.
// When the receiver holds m_axis_tready low, the result register holds and the
// input register fills; s_axis_tready drops only when both are occupied.
// Configuration writes land on the cfg channel (always ready) and should be
// issued while no item is in flight; indexes above five are dropped.
// Reset: registers return to 50, 200, 1100, 2500, 2900, 3750 mV, motors stop,
// orientation forward, distance level two, both stages empty.
`default_nettype none
module field_follow_steering_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: [12:0] left_mv, [25:13] right_mv, [33:26] command_byte, [39:34] zero
  input  logic [ffsc_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: [0] opcode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: [3:0] motor_pattern, [5:4] manoeuvre, [6] backward_mode,
  //        [8:7] level_now, [15:9] zero
  output logic [ffsc_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ffsc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ffsc_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned MvW = ffsc_pkg::MvW;
  localparam int unsigned LvW = ffsc_pkg::LevelW;
  localparam int unsigned PtW = ffsc_pkg::PatW;

  // configuration
  logic [ffsc_pkg::BufW-1:0]   buffer_q;
  logic [ffsc_pkg::LrBufW-1:0] lr_buffer_q;
  logic [MvW-1:0]              level0_q, level1_q, level2_q, level3_q;

  // input stage
  logic                        in_valid_q;
  logic                        opcode_q;
  logic [MvW-1:0]              left_q, right_q;
  logic [ffsc_pkg::CmdW-1:0]   cmd_byte_q;

  // controller state
  logic [PtW-1:0] held_q, held_d;
  logic           orient_q, orient_d;
  logic [LvW-1:0] level_q, level_d;
  ffsc_pkg::man_e man_d;

  // result stage
  logic                            out_valid_q;
  logic [ffsc_pkg::OutDataW-1:0]   out_data_q, out_data_d;

  logic           advance;
  logic           s_fire;
  logic [MvW-1:0] target_mv;
  logic [PtW-1:0] rule_pat;
  ffsc_pkg::cmd_t cmd;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_q    <= ffsc_pkg::BufferRst;
      lr_buffer_q <= ffsc_pkg::LrBufferRst;
      level0_q    <= ffsc_pkg::Level0Rst;
      level1_q    <= ffsc_pkg::Level1Rst;
      level2_q    <= ffsc_pkg::Level2Rst;
      level3_q    <= ffsc_pkg::Level3Rst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ffsc_pkg::RegBuffer:   buffer_q    <= cfg_data_i[ffsc_pkg::BufW-1:0];
        ffsc_pkg::RegLrBuffer: lr_buffer_q <= cfg_data_i[ffsc_pkg::LrBufW-1:0];
        ffsc_pkg::RegLevel0:   level0_q    <= cfg_data_i[MvW-1:0];
        ffsc_pkg::RegLevel1:   level1_q    <= cfg_data_i[MvW-1:0];
        ffsc_pkg::RegLevel2:   level2_q    <= cfg_data_i[MvW-1:0];
        ffsc_pkg::RegLevel3:   level3_q    <= cfg_data_i[MvW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (level_q)
      2'd0:    target_mv = level0_q;
      2'd1:    target_mv = level1_q;
      2'd2:    target_mv = level2_q;
      default: target_mv = level3_q;
    endcase
  end

  ffsc_rules u_rules (
    .left_mv_i      (left_q),
    .right_mv_i     (right_q),
    .target_mv_i    (target_mv),
    .buffer_mv_i    (buffer_q),
    .lr_buffer_mv_i (lr_buffer_q),
    .backward_i     (orient_q),
    .held_i         (held_q),
    .pattern_o      (rule_pat)
  );

  ffsc_cmd u_cmd (
    .command_byte_i (cmd_byte_q),
    .level_i        (level_q),
    .cmd_o          (cmd)
  );

  always_comb begin
    if (opcode_q) begin
      held_d   = ffsc_pkg::PatStop;
      orient_d = orient_q ^ cmd.toggle;
      level_d  = cmd.level_nxt;
      man_d    = cmd.man;
    end else begin
      held_d   = rule_pat;
      orient_d = orient_q;
      level_d  = level_q;
      man_d    = ffsc_pkg::ManNone;
    end
    out_data_d = {{(ffsc_pkg::OutDataW-PtW-LvW-3){1'b0}},
                  level_d, orient_d, man_d, held_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= ffsc_pkg::PatStop;
      orient_q    <= 1'b0;
      level_q     <= ffsc_pkg::LevelRst;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        orient_q    <= orient_d;
        level_q     <= level_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      opcode_q   <= s_axis_tuser;
      left_q     <= s_axis_tdata[MvW-1:0];
      right_q    <= s_axis_tdata[2*MvW-1:MvW];
      cmd_byte_q <= s_axis_tdata[2*MvW+ffsc_pkg::CmdW-1:2*MvW];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
`default_nettype wire
